### rtl/core/aie_pkg.sv
`timescale 1ns / 1ps

package aie_pkg;

   localparam int CMD_W  = 5;
   localparam int MODE_W = 2;
   localparam int OPND_W = 17;
   localparam int ACC_W  = 8;
   localparam int ST_W   = 3;

   localparam logic [CMD_W-1:0] OP_ADD      = 5'd0;
   localparam logic [CMD_W-1:0] OP_SUB      = 5'd1;
   localparam logic [CMD_W-1:0] OP_INC      = 5'd2;
   localparam logic [CMD_W-1:0] OP_DEC      = 5'd3;
   localparam logic [CMD_W-1:0] OP_AND      = 5'd4;
   localparam logic [CMD_W-1:0] OP_OR       = 5'd5;
   localparam logic [CMD_W-1:0] OP_NOT      = 5'd6;
   localparam logic [CMD_W-1:0] OP_SHL      = 5'd7;
   localparam logic [CMD_W-1:0] OP_SHR      = 5'd8;
   localparam logic [CMD_W-1:0] OP_JMP_LO   = 5'd9;
   localparam logic [CMD_W-1:0] OP_JMP_HI   = 5'd15;
   localparam logic [CMD_W-1:0] OP_STORE    = 5'd16;
   localparam logic [CMD_W-1:0] OP_LOAD     = 5'd17;
   localparam logic [CMD_W-1:0] OP_HLT      = 5'd18;

   localparam logic [MODE_W-1:0] MODE_ACC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_IMM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DIR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_IND = 2'd3;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_HALT    = 3'd1;
   localparam logic [ST_W-1:0] ST_BADOPND = 3'd2;
   localparam logic [ST_W-1:0] ST_BADOP   = 3'd3;
   localparam logic [ST_W-1:0] ST_IGNORED = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [MODE_W-1:0] addr_mode;
      logic [OPND_W-1:0] operand_value;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] acc_value;
      logic [ST_W-1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [MODE_W-1:0] addr_mode;
      logic              opnd_ok;
      logic              stopped;
      logic [ACC_W-1:0]  acc;
      logic [ACC_W-1:0]  val;
   } op_type;

   typedef struct packed {
      logic [ACC_W-1:0] acc;
      logic [ST_W-1:0]  status;
      logic             wr_en;
      logic [ACC_W-1:0] wr_data;
      logic             stop;
   } res_type;

endpackage

### rtl/core/aie_regfile.sv
`timescale 1ns / 1ps

module aie_regfile #(
   parameter int REG_COUNT = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(REG_COUNT)-1:0]   wr_addr,
   input  logic [aie_pkg::ACC_W-1:0]      wr_data,
   input  logic                           rd1_en,
   input  logic [$clog2(REG_COUNT)-1:0]   rd1_addr,
   output logic [aie_pkg::ACC_W-1:0]      rd1_data,
   input  logic                           rd2_en,
   input  logic [$clog2(REG_COUNT)-1:0]   rd2_addr,
   output logic [aie_pkg::ACC_W-1:0]      rd2_data
);
   import aie_pkg::*;

   logic [ACC_W-1:0]     mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [REG_COUNT-1:0] vld_in;

   logic [ACC_W-1:0] q1_ff, q2_ff, byp1_data_ff, byp2_data_ff;
   logic             v1_ff, v2_ff, byp1_ff, byp2_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd1_en) begin
         q1_ff <= mem_ff[rd1_addr];
      end
      if (rd2_en) begin
         q2_ff <= mem_ff[rd2_addr];
      end
   end

   // unwritten entries read as zero; a same-cycle write wins over the old word
   always_ff @(posedge clock) begin
      if (rd1_en) begin
         v1_ff        <= vld_ff[rd1_addr];
         byp1_ff      <= wr_en && (wr_addr == rd1_addr);
         byp1_data_ff <= wr_data;
      end
      if (rd2_en) begin
         v2_ff        <= vld_ff[rd2_addr];
         byp2_ff      <= wr_en && (wr_addr == rd2_addr);
         byp2_data_ff <= wr_data;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rd1_data = byp1_ff ? byp1_data_ff : (v1_ff ? q1_ff : '0);
   assign rd2_data = byp2_ff ? byp2_data_ff : (v2_ff ? q2_ff : '0);

endmodule

### rtl/core/aie_alu.sv
`timescale 1ns / 1ps

module aie_alu (
   input  aie_pkg::op_type  op,
   output aie_pkg::res_type res
);
   import aie_pkg::*;

   logic             has_reg;
   logic             acc_mode;
   logic [ACC_W-1:0] a;
   logic [ACC_W-1:0] v;

   assign has_reg  = op.addr_mode[1];
   assign acc_mode = (op.addr_mode == MODE_ACC);
   assign a        = op.acc;
   assign v        = op.val;

   always_comb begin
      res.acc     = a;
      res.status  = ST_OK;
      res.wr_en   = 1'b0;
      res.wr_data = a;
      res.stop    = 1'b0;
      if (op.stopped) begin
         res.status = ST_IGNORED;
      end else if (!op.opnd_ok) begin
         res.status = ST_BADOPND;
         res.stop   = 1'b1;
      end else begin
         case (op.cmd)
            OP_ADD: begin
               res.acc = a + v;
            end
            OP_SUB: begin
               res.acc = a - v;
            end
            OP_INC: begin
               if (has_reg) begin
                  res.wr_en   = 1'b1;
                  res.wr_data = v + 8'd1;
                  res.acc     = v + 8'd1;
               end else if (acc_mode) begin
                  res.acc = a + 8'd1;
               end
            end
            OP_DEC: begin
               if (has_reg) begin
                  res.wr_en   = 1'b1;
                  res.wr_data = v - 8'd1;
                  res.acc     = v - 8'd1;
               end else if (acc_mode) begin
                  res.acc = a - 8'd1;
               end
            end
            OP_AND: begin
               res.acc = a & v;
            end
            OP_OR: begin
               res.acc = a | v;
            end
            OP_NOT: begin
               res.acc = acc_mode ? ~a : ~v;
            end
            OP_SHL: begin
               if (acc_mode) begin
                  res.acc = {a[ACC_W-2:0], 1'b0};
               end else if (has_reg) begin
                  res.acc = {v[ACC_W-2:0], 1'b0};
               end
            end
            OP_SHR: begin
               if (acc_mode) begin
                  res.acc = {a[ACC_W-1], a[ACC_W-1:1]};
               end else if (has_reg) begin
                  res.acc = {v[ACC_W-1], v[ACC_W-1:1]};
               end
            end
            OP_STORE: begin
               res.wr_en = has_reg;
            end
            OP_LOAD: begin
               res.acc = v;
            end
            OP_HLT: begin
               res.status = ST_HALT;
               res.stop   = 1'b1;
            end
            default: begin
               // jumps are no-ops
               if (!(op.cmd inside {[OP_JMP_LO:OP_JMP_HI]})) begin
                  res.status = ST_BADOP;
                  res.stop   = 1'b1;
               end
            end
         endcase
      end
   end

endmodule

### rtl/core/accumulator_instruction_executor_core.sv
`timescale 1ns / 1ps

// Executes one decoded accumulator instruction per item and returns one result item
// (new accumulator, status) per input item. Throughput is one item per cycle while
// rsp_stall is low. The acceptance edge reads the register named by operand_value,
// stage s1 checks the operand and reads the operand register (through the pointer in
// indirect mode), and stage s2 runs the ALU and writes back. The register file is a
// one-write, two-read memory with registered reads and same-cycle write bypass; it
// reads as zero after reset with no clearing pass. After a halt or an error every later
// item returns status "ignored" until reset.

module accumulator_instruction_executor_core #(
   parameter int REG_COUNT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aie_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aie_pkg::rsp_type rsp
);
   import aie_pkg::*;

   localparam int AW = $clog2(REG_COUNT);

   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_req_ff;
   logic             s2_valid_ff, s2_valid_in;
   logic [CMD_W-1:0] s2_cmd_ff;
   logic [MODE_W-1:0] s2_mode_ff;
   logic [ACC_W-1:0] s2_imm_ff;
   logic [AW-1:0]    s2_tgt_ff;
   logic             s2_opnd_ok_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             stopped_ff, stopped_in;

   logic             req_accept, s1_adv, s2_adv, s1_free, s2_free, out_free;
   logic [ACC_W-1:0] rd1_data, rd2_data, ptr;
   logic [AW-1:0]    num_idx, s1_tgt;
   logic             num_ok, ptr_ok, s1_opnd_ok, wr_en;
   op_type           op;
   res_type          res;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s2_adv     = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_stall  = !s1_free;
   assign req_accept = req_valid && !req_stall;

   assign wr_en = s2_adv && res.wr_en;

   aie_regfile #(
      .REG_COUNT(REG_COUNT)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (s2_tgt_ff),
      .wr_data  (res.wr_data),
      .rd1_en   (req_accept),
      .rd1_addr (req.operand_value[AW-1:0]),
      .rd1_data (rd1_data),
      .rd2_en   (s1_adv),
      .rd2_addr (s1_tgt),
      .rd2_data (rd2_data)
   );

   // operand check and target selection; the older item's write lands in the same cycle
   assign num_idx = s1_req_ff.operand_value[AW-1:0];
   assign num_ok  = s1_req_ff.operand_value < OPND_W'(REG_COUNT);
   assign ptr     = (wr_en && (s2_tgt_ff == num_idx)) ? res.wr_data : rd1_data;
   assign ptr_ok  = !ptr[ACC_W-1] && ({1'b0, ptr} < (ACC_W + 1)'(REG_COUNT));
   assign s1_tgt  = (s1_req_ff.addr_mode == MODE_IND) ? ptr[AW-1:0] : num_idx;

   always_comb begin
      case (s1_req_ff.addr_mode)
         MODE_DIR: s1_opnd_ok = num_ok;
         MODE_IND: s1_opnd_ok = num_ok && ptr_ok;
         default:  s1_opnd_ok = 1'b1;
      endcase
   end

   always_comb begin
      op.cmd       = s2_cmd_ff;
      op.addr_mode = s2_mode_ff;
      op.opnd_ok   = s2_opnd_ok_ff;
      op.stopped   = stopped_ff;
      op.acc       = acc_ff;
      case (s2_mode_ff)
         MODE_ACC: op.val = '0;
         MODE_IMM: op.val = s2_imm_ff;
         default:  op.val = rd2_data;
      endcase
   end

   aie_alu u_alu (
      .op  (op),
      .res (res)
   );

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_adv);
   assign s2_valid_in  = s1_adv || (s2_valid_ff && !s2_adv);
   assign out_valid_in = s2_adv || (out_valid_ff && rsp_stall);
   assign acc_in       = s2_adv ? res.acc : acc_ff;
   assign stopped_in   = stopped_ff || (s2_adv && res.stop);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         stopped_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         stopped_ff   <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req;
      end
      if (s1_adv) begin
         s2_cmd_ff     <= s1_req_ff.cmd;
         s2_mode_ff    <= s1_req_ff.addr_mode;
         s2_imm_ff     <= s1_req_ff.operand_value[ACC_W-1:0];
         s2_tgt_ff     <= s1_tgt;
         s2_opnd_ok_ff <= s1_opnd_ok;
      end
      if (s2_adv) begin
         out_ff.acc_value <= res.acc;
         out_ff.status    <= res.status;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

### rtl/core/aie_checker.sv
`timescale 1ns / 1ps

module aie_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input aie_pkg::rsp_type rsp
);
   import aie_pkg::*;

   logic                    req_fire, rsp_fire;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    stop_seen_ff;
   logic signed [ACC_W-1:0] last_acc_ff;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_fire && !rsp_fire) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         stop_seen_ff <= 1'b0;
         last_acc_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (rsp_fire) begin
            last_acc_ff <= rsp.acc_value;
            if (rsp.status == ST_HALT || rsp.status == ST_BADOPND
                || rsp.status == ST_BADOP) begin
               stop_seen_ff <= 1'b1;
            end
         end
      end
   end

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 2'd0)
      else $error("result item with no item in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !rsp_fire) |-> cnt_ff != 2'd3)
      else $error("more than three items in flight");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && stop_seen_ff) |-> rsp.status == ST_IGNORED)
      else $error("item executed after stop");

   a_acc_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp.status != ST_OK) |-> rsp.acc_value == last_acc_ff)
      else $error("accumulator changed on a non-ok item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled result item changed");

endmodule

bind accumulator_instruction_executor_core aie_checker u_aie_checker (.*);
